### rtl/dawp_pkg.sv
// ============================================================================
// dawp_pkg
// Shared types and constants for the digitizer aggregate word parser.
// ============================================================================
package dawp_pkg;

  // Number of channel pairs whose mask bits are honored (1..8)
  localparam int unsigned CHANNEL_PAIRS = 8;
  // Pair index width, fixed by the 4-bit channel number
  localparam int unsigned PAIR_IDX_W = 3;
  localparam int unsigned MAX_PAIRS  = 8;

  // Input beat: one readout word plus packet marker
  typedef struct packed {
    logic [31:0] data_word;
    logic        packet_end;
  } in_item_t;

  // Result beat: sample record or event summary
  typedef struct packed {
    logic        record_kind;
    logic [3:0]  channel;
    logic [30:0] time_tag;
    logic [13:0] sample_a;
    logic [13:0] sample_b;
    logic [1:0]  digital_bits;
    logic [1:0]  trigger_bits;
    logic        dual_trace;
    logic [14:0] energy;
    logic        pileup_flag;
    logic [4:0]  extras_code;
    logic [31:0] extras_word;
  } out_item_t;

  // Record kinds
  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Result of the enabled-pair search
  typedef struct packed {
    logic                  found;
    logic [PAIR_IDX_W-1:0] index;
  } seek_t;

endpackage

### rtl/dawp_pair_seek.sv
// ============================================================================
// dawp_pair_seek
// Finds the lowest enabled channel pair at or above a start index.
// ============================================================================
module dawp_pair_seek #(
  parameter int unsigned CHANNEL_PAIRS = dawp_pkg::CHANNEL_PAIRS
) (
  input  logic [dawp_pkg::MAX_PAIRS-1:0] pair_mask,
  input  logic [dawp_pkg::PAIR_IDX_W:0]  start,
  output dawp_pkg::seek_t                seek
);

  logic [CHANNEL_PAIRS-1:0] hit;

  // Candidate pairs: enabled and not below the start point
  always_comb begin
    for (int i = 0; i < CHANNEL_PAIRS; i++) begin
      hit[i] = pair_mask[i] && (start <= (dawp_pkg::PAIR_IDX_W+1)'(i));
    end
  end

  // Lowest candidate wins: scan from the top so the last write is the lowest
  always_comb begin
    seek.found = 1'b0;
    seek.index = '0;
    for (int i = CHANNEL_PAIRS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        seek.found = 1'b1;
        seek.index = (dawp_pkg::PAIR_IDX_W)'(i);
      end
    end
  end

endmodule

### rtl/digitizer_aggregate_word_parser.sv
// ============================================================================
// digitizer_aggregate_word_parser
// Walks a digitizer readout stream and emits sample records and summaries.
// ============================================================================
// Takes one 32-bit readout word per beat and walks the aggregate layout:
// a 4-word board header (word 1 holds the pair enable mask), a 2-word channel
// header per enabled pair, then events made of a time-tag word, sample words
// and two extras words. Each sample word yields a sample record, the second
// extras word an event summary; all other words yield nothing. A word marked
// packet_end is parsed normally and then the parser resyncs to the board
// header. A word taken sits in the input register, and the parse of it writes
// its result into the output buffer; one word can be taken every cycle while
// the skid entry is empty, since each word is handled by a single pass of
// field extraction, one 31-bit compare/subtract for the remaining-word
// countdown and an 8-entry priority pick. A two-entry output buffer lets
// input flow on while one result waits to be taken.
module digitizer_aggregate_word_parser #(
  parameter int unsigned CHANNEL_PAIRS = dawp_pkg::CHANNEL_PAIRS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dawp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dawp_pkg::out_item_t out_data
);

  typedef enum logic [2:0] {
    PH_BOARD,
    PH_CHAN0,
    PH_CHAN1,
    PH_TTAG,
    PH_SAMPLE,
    PH_EXTRA1,
    PH_EXTRA2
  } phase_t;

  // Input register
  logic               s1_valid_r;
  dawp_pkg::in_item_t s1_item_r;

  // Parser state
  phase_t                          phase_r, phase_nxt;
  logic [1:0]                      hwi_r, hwi_nxt;
  logic [dawp_pkg::MAX_PAIRS-1:0]  mask_r, mask_nxt;
  logic [dawp_pkg::PAIR_IDX_W-1:0] pidx_r, pidx_nxt;
  logic [30:0]                     awl_r, awl_nxt;
  logic [17:0]                     spe_r, spe_nxt;
  logic [17:0]                     swc_r, swc_nxt;
  logic                            dt_r, dt_nxt;
  logic [3:0]                      ch_r, ch_nxt;
  logic [30:0]                     tt_r, tt_nxt;
  logic [31:0]                     held_r, held_nxt;

  // Output buffer: head drives the port, skid catches one more
  logic                head_v_r, skid_v_r;
  dawp_pkg::out_item_t head_r, skid_r;

  logic                advance;
  logic                push;
  logic                pop;
  dawp_pkg::out_item_t res;

  logic [31:0] w;
  logic [17:0] spe_sel;
  logic [18:0] need;
  logic        event_ok;
  logic [17:0] swc_inc;

  logic [dawp_pkg::PAIR_IDX_W:0] seek_start;
  dawp_pkg::seek_t               seek;

  assign w       = s1_item_r.data_word;
  assign advance = s1_valid_r && !skid_v_r;
  assign pop     = head_v_r && !out_stall;

  assign in_stall  = s1_valid_r && skid_v_r;
  assign out_valid = head_v_r;
  assign out_data  = head_r;

  // Countdown check: sample words of one event plus time tag and two extras
  assign spe_sel  = (phase_r == PH_CHAN1) ? {w[15:0], 2'b00} : spe_r;
  assign need     = {1'b0, spe_sel} + 19'd3;
  assign event_ok = awl_r >= {12'd0, need};
  assign swc_inc  = swc_r + 18'd1;

  // Board header restarts the search at pair 0, channel headers and events move past the current pair
  assign seek_start = (phase_r == PH_CHAN1 || phase_r == PH_EXTRA2)
                    ? {1'b0, pidx_r} + (dawp_pkg::PAIR_IDX_W+1)'(1)
                    : '0;

  dawp_pair_seek #(
    .CHANNEL_PAIRS(CHANNEL_PAIRS)
  ) u_seek (
    .pair_mask(mask_r),
    .start    (seek_start),
    .seek     (seek)
  );

  // Per-word parse
  always_comb begin
    phase_nxt = phase_r;
    hwi_nxt   = hwi_r;
    mask_nxt  = mask_r;
    pidx_nxt  = pidx_r;
    awl_nxt   = awl_r;
    spe_nxt   = spe_r;
    swc_nxt   = swc_r;
    dt_nxt    = dt_r;
    ch_nxt    = ch_r;
    tt_nxt    = tt_r;
    held_nxt  = held_r;
    push      = 1'b0;
    res       = '0;
    res.channel    = ch_r;
    res.time_tag   = tt_r;
    res.dual_trace = dt_r;

    unique case (phase_r)
      PH_CHAN0: begin
        awl_nxt   = (w[30:0] >= 31'd2) ? w[30:0] - 31'd2 : 31'd0;
        phase_nxt = PH_CHAN1;
      end
      PH_CHAN1: begin
        dt_nxt  = w[31];
        spe_nxt = spe_sel;
        if (event_ok) begin
          awl_nxt   = awl_r - {12'd0, need};
          phase_nxt = PH_TTAG;
        end else if (seek.found) begin
          pidx_nxt  = seek.index;
          phase_nxt = PH_CHAN0;
        end else begin
          phase_nxt = PH_BOARD;
          hwi_nxt   = 2'd0;
        end
      end
      PH_TTAG: begin
        tt_nxt    = w[30:0];
        ch_nxt    = {pidx_r, w[31]};
        swc_nxt   = '0;
        phase_nxt = (spe_r == 18'd0) ? PH_EXTRA1 : PH_SAMPLE;
      end
      PH_SAMPLE: begin
        push             = 1'b1;
        res.record_kind  = dawp_pkg::KIND_SAMPLE;
        res.sample_a     = w[13:0];
        res.sample_b     = w[29:16];
        res.digital_bits = {w[30], w[14]};
        res.trigger_bits = {w[31], w[15]};
        swc_nxt          = swc_inc;
        if (swc_inc >= spe_r) phase_nxt = PH_EXTRA1;
      end
      PH_EXTRA1: begin
        held_nxt  = w;
        phase_nxt = PH_EXTRA2;
      end
      PH_EXTRA2: begin
        push            = 1'b1;
        res.record_kind = dawp_pkg::KIND_SUMMARY;
        res.energy      = w[14:0];
        res.pileup_flag = w[15];
        res.extras_code = w[20:16];
        res.extras_word = held_r;
        if (event_ok) begin
          awl_nxt   = awl_r - {12'd0, need};
          phase_nxt = PH_TTAG;
        end else if (seek.found) begin
          pidx_nxt  = seek.index;
          phase_nxt = PH_CHAN0;
        end else begin
          phase_nxt = PH_BOARD;
          hwi_nxt   = 2'd0;
        end
      end
      default: begin
        // Board header words
        phase_nxt = PH_BOARD;
        if (hwi_r == 2'd1) mask_nxt = w[dawp_pkg::MAX_PAIRS-1:0];
        if (hwi_r == 2'd3) begin
          hwi_nxt = 2'd0;
          if (seek.found) begin
            pidx_nxt  = seek.index;
            phase_nxt = PH_CHAN0;
          end
        end else begin
          hwi_nxt = hwi_r + 2'd1;
        end
      end
    endcase

    // Packet end resyncs to the board header
    if (s1_item_r.packet_end) begin
      phase_nxt = PH_BOARD;
      hwi_nxt   = 2'd0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
    if (!in_stall && in_valid) s1_item_r <= in_data;
  end

  // Parser state and output buffer (head and skid beats)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_BOARD;
      hwi_r    <= '0;
      mask_r   <= '0;
      pidx_r   <= '0;
      awl_r    <= '0;
      spe_r    <= '0;
      swc_r    <= '0;
      dt_r     <= 1'b0;
      ch_r     <= '0;
      tt_r     <= '0;
      held_r   <= '0;
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (advance) begin
        phase_r <= phase_nxt;
        hwi_r   <= hwi_nxt;
        mask_r  <= mask_nxt;
        pidx_r  <= pidx_nxt;
        awl_r   <= awl_nxt;
        spe_r   <= spe_nxt;
        swc_r   <= swc_nxt;
        dt_r    <= dt_nxt;
        ch_r    <= ch_nxt;
        tt_r    <= tt_nxt;
        held_r  <= held_nxt;
      end
      if (pop) begin
        if (skid_v_r) begin
          head_v_r <= 1'b1;
          skid_v_r <= 1'b0;
        end else begin
          head_v_r <= advance && push;
        end
      end else if (advance && push) begin
        if (head_v_r) skid_v_r <= 1'b1;
        else          head_v_r <= 1'b1;
      end
    end
    if (pop) begin
      if (skid_v_r) head_r <= skid_r;
      else if (advance && push) head_r <= res;
    end else if (advance && push) begin
      if (head_v_r) skid_r <= res;
      else          head_r <= res;
    end
  end

endmodule
